[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define DHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define DHT_ASSERT_NEVER(lbl, prop, msg) \
  `DHT_ASSERT(lbl, !(prop), msg)

`endif

[rtl/dht_pkg.sv]
// ----------------------------------------------------------------------------
// dht_pkg
// shared types and constants of the double hashing hash table
// ----------------------------------------------------------------------------
package dht_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int KEY_W         = 32;
  localparam int SLOT_W        = 4;
  localparam int POS_W         = 4;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [2:0] STEP_BASE = 3'd7;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_ZERO_KEY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_SEARCH,
    OP_READ,
    OP_ZERO,
    OP_BAD
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [KEY_W-1:0]   key;
    logic [SLOT_W-1:0]  slot;
  } job_t;

endpackage

[rtl/dht_ram.sv]
// ----------------------------------------------------------------------------
// dht_ram
// single port ram, one read or write per cycle, registered read data
// ----------------------------------------------------------------------------
module dht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/dht_queue.sv]
// ----------------------------------------------------------------------------
// dht_queue
// small fifo between the classifying front end and the probing back end
// ----------------------------------------------------------------------------
module dht_queue import dht_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        entry_q[wr_q] <= data_i;
        wr_q <= (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  assign data_o  = entry_q[rd_q];
  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);

endmodule

[rtl/dht_front.sv]
// ----------------------------------------------------------------------------
// dht_front
// takes a transaction, classifies it and works out home slot and step
// ----------------------------------------------------------------------------
module dht_front import dht_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [1:0]                 mode_i,
  input  logic [KEY_W-1:0]           key_i,
  input  logic [SLOT_W-1:0]          slot_i,
  input  logic                       full_i,
  output logic                       push_o,
  output job_t                       job_o,
  output logic [$clog2(SLOTS)-1:0]   home_o,
  output logic [$clog2(SLOTS)-1:0]   stepm_o,
  output logic                       busy_o
);

  localparam int PW = $clog2(SLOTS);
  localparam int SW = $clog2(SLOTS + 1);
  localparam int TW = SW + 8;
  localparam int UW = SW + 3;

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} state_e;

  state_e           state_q;
  job_t             job_q;
  logic [KEY_W-1:0] shift_q;
  logic [1:0]       cnt_q;
  logic [PW-1:0]    rs_q;
  logic [2:0]       r7_q;

  op_e              op_in;
  logic [PW-1:0]    rs_nx;
  logic [2:0]       r7_nx;
  logic [2:0]       step;

  always_comb begin
    op_in = OP_BAD;
    case (mode_i)
      MODE_INSERT: op_in = (key_i == '0) ? OP_ZERO : OP_INSERT;
      MODE_SEARCH: op_in = (key_i == '0) ? OP_ZERO : OP_SEARCH;
      MODE_READ:   op_in = OP_READ;
      default:     op_in = OP_BAD;
    endcase
  end

  // one byte of the key per cycle, msb first, restoring reduction
  always_comb begin
    logic [TW-1:0] t;
    logic [10:0]   t7;
    t  = TW'({rs_q, shift_q[KEY_W-1 -: 8]});
    t7 = {r7_q, shift_q[KEY_W-1 -: 8]};
    for (int k = 7; k >= 0; k--) begin
      if (t >= (TW'(SLOTS) << k)) begin
        t = t - (TW'(SLOTS) << k);
      end
      if (t7 >= (11'(STEP_BASE) << k)) begin
        t7 = t7 - (11'(STEP_BASE) << k);
      end
    end
    rs_nx = t[PW-1:0];
    r7_nx = t7[2:0];
  end

  // step in 1..7, folded into the table range
  always_comb begin
    logic [UW-1:0] s;
    step = STEP_BASE - r7_q;
    s    = UW'(step);
    for (int k = 2; k >= 0; k--) begin
      if (s >= (UW'(SLOTS) << k)) begin
        s = s - (UW'(SLOTS) << k);
      end
    end
    stepm_o = s[PW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (accept_i) begin
            job_q.op   <= op_in;
            job_q.key  <= key_i;
            job_q.slot <= slot_i;
            shift_q    <= key_i;
            cnt_q      <= '0;
            rs_q       <= '0;
            r7_q       <= '0;
            state_q    <= (op_in == OP_INSERT || op_in == OP_SEARCH) ? F_HASH : F_PUSH;
          end
        end
        F_HASH: begin
          rs_q    <= rs_nx;
          r7_q    <= r7_nx;
          shift_q <= shift_q << 8;
          cnt_q   <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign push_o = (state_q == F_PUSH) && !full_i;
  assign job_o  = job_q;
  assign home_o = rs_q;
  assign busy_o = (state_q != F_IDLE);

endmodule

[rtl/dht_back.sv]
// ----------------------------------------------------------------------------
// dht_back
// clears the slot store, then runs queued jobs one probe per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dht_back import dht_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     empty_i,
  input  job_t                     job_i,
  input  logic [$clog2(SLOTS)-1:0] home_i,
  input  logic [$clog2(SLOTS)-1:0] stepm_i,
  output logic                     pop_o,
  output logic                     clearing_o,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic [POS_W-1:0]         position_o,
  output logic [KEY_W-1:0]         slot_value_o
);

  localparam int PW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = (PW > SLOT_W) ? PW : SLOT_W;

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_PROBE, B_READ} state_e;

  state_e             state_q;
  logic [PW-1:0]      clr_q;
  op_e                op_q;
  logic [KEY_W-1:0]   key_q;
  logic [PW-1:0]      stepm_q;
  logic [PW-1:0]      cur_q;
  logic [CW-1:0]      cnt_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               done_q;
  status_e            status_q;
  logic [POS_W-1:0]   pos_q;
  logic [KEY_W-1:0]   value_q;

  logic               ram_we;
  logic [PW-1:0]      ram_addr;
  logic [KEY_W-1:0]   ram_wdata;
  logic [KEY_W-1:0]   ram_rdata;

  logic [PW-1:0]      nxt;
  logic [PW:0]        sum;
  logic [IW:0]        slot_ext;
  logic               slot_ok;
  logic [IW-1:0]      cur_ext;
  logic               hit_empty, hit_key;

  dht_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // next probe slot
  always_comb begin
    sum = {1'b0, cur_q} + {1'b0, stepm_q};
    if (sum >= (PW+1)'(SLOTS)) begin
      sum = sum - (PW+1)'(SLOTS);
    end
    nxt = sum[PW-1:0];
  end

  assign slot_ext  = (IW+1)'(job_i.slot);
  assign slot_ok   = slot_ext < (IW+1)'(SLOTS);
  assign cur_ext   = IW'(cur_q);
  assign hit_empty = (ram_rdata == '0);
  assign hit_key   = (ram_rdata == key_q);
  assign pop_o     = (state_q == B_IDLE) && !empty_i;

  // store port: clear sweep, dispatch read, probe read ahead or insert write
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = cur_q;
    ram_wdata = key_q;
    case (state_q)
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      B_IDLE: begin
        ram_addr = (job_i.op == OP_READ) ? slot_ext[PW-1:0] : home_i;
      end
      B_PROBE: begin
        if (op_q == OP_INSERT && hit_empty) begin
          ram_we = 1'b1;
        end else begin
          ram_addr = nxt;
        end
      end
      default: ram_addr = cur_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        B_CLEAR: begin
          clr_q <= clr_q + PW'(1);
          if (clr_q == PW'(SLOTS - 1)) begin
            state_q <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!empty_i) begin
            op_q    <= job_i.op;
            key_q   <= job_i.key;
            stepm_q <= stepm_i;
            cur_q   <= home_i;
            cnt_q   <= '0;
            slot_q  <= job_i.slot;
            case (job_i.op)
              OP_INSERT, OP_SEARCH: state_q <= B_PROBE;
              OP_READ: begin
                if (slot_ok) begin
                  state_q <= B_READ;
                end else begin
                  done_q   <= 1'b1;
                  status_q <= ST_NOT_FOUND;
                  pos_q    <= job_i.slot;
                  value_q  <= '0;
                end
              end
              OP_ZERO: begin
                done_q   <= 1'b1;
                status_q <= ST_ZERO_KEY;
                pos_q    <= '0;
                value_q  <= '0;
              end
              default: begin
                done_q   <= 1'b1;
                status_q <= ST_NOT_FOUND;
                pos_q    <= '0;
                value_q  <= '0;
              end
            endcase
          end
        end
        B_READ: begin
          done_q   <= 1'b1;
          status_q <= ST_DONE;
          pos_q    <= slot_q;
          value_q  <= ram_rdata;
          state_q  <= B_IDLE;
        end
        B_PROBE: begin
          value_q <= '0;
          if (op_q == OP_INSERT) begin
            if (hit_empty) begin
              done_q   <= 1'b1;
              status_q <= ST_DONE;
              pos_q    <= cur_ext[POS_W-1:0];
              state_q  <= B_IDLE;
            end else if (cnt_q == CW'(SLOTS - 1)) begin
              done_q   <= 1'b1;
              status_q <= ST_FULL;
              pos_q    <= '0;
              state_q  <= B_IDLE;
            end else begin
              cur_q <= nxt;
              cnt_q <= cnt_q + CW'(1);
            end
          end else begin
            if (hit_key) begin
              done_q   <= 1'b1;
              status_q <= ST_DONE;
              pos_q    <= cur_ext[POS_W-1:0];
              state_q  <= B_IDLE;
            end else if (hit_empty || cnt_q == CW'(SLOTS)) begin
              done_q   <= 1'b1;
              status_q <= ST_NOT_FOUND;
              pos_q    <= '0;
              state_q  <= B_IDLE;
            end else begin
              cur_q <= nxt;
              cnt_q <= cnt_q + CW'(1);
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign clearing_o   = (state_q == B_CLEAR);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign position_o   = pos_q;
  assign slot_value_o = value_q;

  `DHT_ASSERT(a_probe_bound, (state_q == B_PROBE) |-> (cnt_q <= CW'(SLOTS)), "probe count past table size")
  `DHT_ASSERT(a_write_on_empty, (ram_we && state_q != B_CLEAR) |-> (op_q == OP_INSERT && ram_rdata == '0), "store write outside an insert into an empty slot")
  `DHT_ASSERT_NEVER(a_stray_value, done_q && status_q != ST_DONE && value_q != '0, "slot value set on a failed result")

endmodule

[rtl/double_hash_table_top.sv]
// ----------------------------------------------------------------------------
// double_hash_table_top
// open addressed hash table of nonzero keys with double hashing
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  command   start / busy              mode_i, key_i, slot_i
//  result    done_o (one-cycle strobe) status_o, position_o, slot_value_o
//
//  front end: accept cycle, then for insert and search folding the key a
//  byte at a time into home slot and step, then the job waits for queue room
//  back end: dispatch, then one store probe per cycle; insert probes
//  up to SLOTS slots, search up to SLOTS+1, read one store read, others none
//  after reset the store is swept to zero with busy high
//  results cannot be stalled; the two-entry queue lets hashing overlap probing
//
module double_hash_table_top import dht_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [SLOT_W-1:0]  slot_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [POS_W-1:0]   position_o,
  output logic [KEY_W-1:0]   slot_value_o
);

  localparam int PW = $clog2(SLOTS);
  localparam int JW = $bits(job_t);
  localparam int QW = JW + 2 * PW;

  // transaction handshake
  logic          accept;
  logic          front_busy;
  logic          clearing;

  // front end to queue
  logic          push;
  job_t          front_job;
  logic [PW-1:0] front_home;
  logic [PW-1:0] front_stepm;
  logic          q_full;

  // queue to back end
  logic [QW-1:0] q_head;
  logic          q_empty;
  logic          pop;
  job_t          back_job;
  logic [PW-1:0] back_home;
  logic [PW-1:0] back_stepm;

  // no transaction while hashing, handing on a job or clearing the store
  assign busy   = front_busy || clearing;
  assign accept = start && !busy;

  dht_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .mode_i   (mode_i),
    .key_i    (key_i),
    .slot_i   (slot_i),
    .full_i   (q_full),
    .push_o   (push),
    .job_o    (front_job),
    .home_o   (front_home),
    .stepm_o  (front_stepm),
    .busy_o   (front_busy)
  );

  // queue entry: job, home slot, folded step
  dht_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({front_job, front_home, front_stepm}),
    .pop_i   (pop),
    .data_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign back_job   = q_head[QW-1 -: JW];
  assign back_home  = q_head[2*PW-1 -: PW];
  assign back_stepm = q_head[PW-1:0];

  // probing engine owns the slot store and the result registers
  dht_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .job_i        (back_job),
    .home_i       (back_home),
    .stepm_i      (back_stepm),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .done_o       (done_o),
    .status_o     (status_o),
    .position_o   (position_o),
    .slot_value_o (slot_value_o)
  );

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// double hash table testbench
// drives insert, search, read and unused-mode commands into the table,
// mirrors the slot store in a scoreboard and checks every reply in order
// ----------------------------------------------------------------------------
module testbench;
  import dht_pkg::*;

  localparam int TABLE_SLOTS = SLOTS_DEFAULT;
  localparam int MAX_GAP     = 17;
  localparam int RANDOM_CMDS = 600;
  localparam int DRAIN_WAIT  = 40;

  // mode 3 has no name in the package; it must answer not found
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // keys that are 0 mod 16 and 5 mod 7 share home slot 0 and step 2,
  // so they only ever reach the even slots
  localparam int unsigned EVEN_CHAIN_BASE  = 96;
  localparam int unsigned RESIDUE_PERIOD   = 112;
  localparam int unsigned EVEN_CHAIN_LIMIT = 38347921;

  typedef struct {
    status_e            status;
    logic [POS_W-1:0]   position;
    logic [KEY_W-1:0]   value;
  } reply_t;

  // --------------------------------------------------------------------------
  // scoreboard: mirror of the slot store plus the replies still owed
  // --------------------------------------------------------------------------
  class hash_table_scoreboard;
    logic [KEY_W-1:0] slot_mirror [TABLE_SLOTS];
    reply_t           pending_replies [$];
    int unsigned      mismatches;
    int unsigned      stray_replies;
    int unsigned      replies_checked;
    int unsigned      n_stored, n_full, n_found, n_missed, n_reads, n_zero, n_unused;

    function new();
      foreach (slot_mirror[i]) slot_mirror[i] = '0;
    endfunction

    // probe i of a key: home slot plus i steps, step in 1..7
    function int unsigned probe_at(logic [KEY_W-1:0] key, int unsigned i);
      int unsigned home;
      int unsigned stride;
      home   = key % TABLE_SLOTS;
      stride = 7 - (key % 7);
      return (home + i * stride) % TABLE_SLOTS;
    endfunction

    // work out the reply of an accepted command and update the mirror
    function void record_command(logic [1:0] mode, logic [KEY_W-1:0] key,
                                 logic [SLOT_W-1:0] slot);
      reply_t      r;
      int unsigned p;
      bit          settled;
      r.status   = ST_NOT_FOUND;
      r.position = '0;
      r.value    = '0;
      settled    = 1'b0;
      case (mode)
        MODE_INSERT: begin
          if (key == '0) begin
            r.status = ST_ZERO_KEY;
            n_zero++;
          end else begin
            r.status = ST_FULL;
            for (int i = 0; i < TABLE_SLOTS && !settled; i++) begin
              p = probe_at(key, i);
              if (slot_mirror[p] == '0) begin
                slot_mirror[p] = key;
                r.status   = ST_DONE;
                r.position = p[POS_W-1:0];
                settled    = 1'b1;
              end
            end
            if (settled) n_stored++;
            else n_full++;
          end
        end
        MODE_SEARCH: begin
          if (key == '0) begin
            r.status = ST_ZERO_KEY;
            n_zero++;
          end else begin
            // home slot, then up to SLOTS more probes; empty slot ends it
            for (int i = 0; i <= TABLE_SLOTS && !settled; i++) begin
              p = probe_at(key, i);
              if (slot_mirror[p] == key) begin
                r.status   = ST_DONE;
                r.position = p[POS_W-1:0];
                settled    = 1'b1;
              end else if (slot_mirror[p] == '0) begin
                settled = 1'b1;
              end
            end
            if (r.status == ST_DONE) n_found++;
            else n_missed++;
          end
        end
        MODE_READ: begin
          n_reads++;
          r.position = slot;
          if (slot < TABLE_SLOTS) begin
            r.status = ST_DONE;
            r.value  = slot_mirror[slot];
          end
        end
        default: n_unused++;
      endcase
      pending_replies.push_back(r);
    endfunction

    function void compare_reply(logic [1:0] status, logic [POS_W-1:0] position,
                                logic [KEY_W-1:0] value);
      reply_t want;
      if (pending_replies.size() == 0) begin
        stray_replies++;
        if (mismatches + stray_replies <= 10)
          $display("reply with nothing outstanding: status %0d position %0d value %h",
                   status, position, value);
        return;
      end
      want = pending_replies.pop_front();
      replies_checked++;
      if (status !== want.status || position !== want.position || value !== want.value) begin
        mismatches++;
        if (mismatches + stray_replies <= 10)
          $display("reply %0d differs: expected %0d/%0d/%h, got %0d/%0d/%h",
                   replies_checked, want.status, want.position, want.value,
                   status, position, value);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        mode_i;
  logic [KEY_W-1:0]  key_i;
  logic [SLOT_W-1:0] slot_i;
  logic              done_o;
  logic [1:0]        status_o;
  logic [POS_W-1:0]  position_o;
  logic [KEY_W-1:0]  slot_value_o;

  double_hash_table_top #(
    .SLOTS(TABLE_SLOTS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .mode_i      (mode_i),
    .key_i       (key_i),
    .slot_i      (slot_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .position_o  (position_o),
    .slot_value_o(slot_value_o)
  );

  hash_table_scoreboard sb;

  // keys already sent, reused so that searches hit and probe chains grow
  logic [KEY_W-1:0] key_pool [$];
  bit               back_to_back;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // monitor: all sampling at the rising edge sees pre-edge values, so the
  // command transaction and the reply strobe are read race free
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (start && busy === 1'b0)
        sb.record_command(mode_i, key_i, slot_i);
      if (done_o === 1'b1)
        sb.compare_reply(status_o, position_o, slot_value_o);
    end
  end

  // one command transaction: optional idle gap, then start high until busy low;
  // with a zero gap start simply stays high into the next command
  task automatic issue_command(input logic [1:0] mode, input logic [KEY_W-1:0] key,
                               input logic [SLOT_W-1:0] slot);
    int unsigned gap;
    gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    mode_i <= mode;
    key_i  <= key;
    slot_i <= slot;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    if (key != '0 && (mode == MODE_INSERT || mode == MODE_SEARCH))
      key_pool.push_back(key);
  endtask

  // a key with home slot 0 and step 2
  function automatic logic [KEY_W-1:0] even_chain_key();
    longint unsigned k;
    k = longint'(RESIDUE_PERIOD) * $urandom_range(0, EVEN_CHAIN_LIMIT) + EVEN_CHAIN_BASE;
    return k[KEY_W-1:0];
  endfunction

  // mix of fresh, repeated, colliding and small keys
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned pick;
    logic [KEY_W-1:0] base;
    pick = $urandom_range(0, 9);
    if (key_pool.size() == 0 || pick < 3) return $urandom();
    base = key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (pick < 7) return base;
    // same residues mod 16 and mod 7: same home slot and step, other key
    if (pick < 9) return base + RESIDUE_PERIOD * $urandom_range(1, 50);
    return $urandom_range(1, 300);
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [KEY_W-1:0] chain_keys [9];
    int unsigned      roll;
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;

    sb           = new();
    back_to_back = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    mode_i       = MODE_INSERT;
    key_i        = '0;
    slot_i       = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, zero key, unused mode, extreme key and slots
    issue_command(MODE_READ,   '0, '0);
    issue_command(MODE_SEARCH, '1, '0);
    issue_command(MODE_INSERT, '0, '1);
    issue_command(MODE_SEARCH, '0, '0);
    issue_command(MODE_UNUSED, '1, '1);
    issue_command(MODE_INSERT, '1, '0);
    issue_command(MODE_SEARCH, '1, '1);
    issue_command(MODE_READ,   '0, '1);

    // eight keys on the even-slot chain fill it; the ninth finds no empty
    // slot on its probe sequence though all odd slots but 15 are still free
    foreach (chain_keys[i]) chain_keys[i] = even_chain_key();
    foreach (chain_keys[i]) issue_command(MODE_INSERT, chain_keys[i], '0);
    // found at the end of a long chain
    issue_command(MODE_SEARCH, chain_keys[7], '0);
    // same chain but absent: every probe hits an occupied slot
    issue_command(MODE_SEARCH, even_chain_key() ^ 32'h0, '0);
    // duplicate insert is stored again elsewhere
    issue_command(MODE_INSERT, '1, '0);
    issue_command(MODE_INSERT, 32'd1, '0);
    issue_command(MODE_READ,   '0, 4'd14);

    // random part: few inserts, so the table fills slowly and partly
    // filled states get plenty of searches and reads
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 32 == 0) back_to_back = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      key  = pick_key();
      if (roll < 9) mode = MODE_INSERT;
      else if (roll < 55) mode = MODE_SEARCH;
      else if (roll < 92) mode = MODE_READ;
      else if (roll < 96) mode = MODE_UNUSED;
      else begin
        mode = roll[0] ? MODE_SEARCH : MODE_INSERT;
        key  = '0;
      end
      issue_command(mode, key, SLOT_W'($urandom_range(0, TABLE_SLOTS - 1)));
    end
    start <= 1'b0;

    // drain the outstanding replies, then watch for strays
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("commands checked: %0d (stored %0d, full %0d, found %0d, missed %0d)",
             sb.replies_checked, sb.n_stored, sb.n_full, sb.n_found, sb.n_missed);
    $display("reads %0d, zero key %0d, unused mode %0d, mismatches %0d, strays %0d",
             sb.n_reads, sb.n_zero, sb.n_unused, sb.mismatches, sb.stray_replies);
    if (sb.mismatches == 0 && sb.stray_replies == 0 && sb.pending_replies.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
